FILE: src/tvjq_pkg.sv
// Package for the timed valve job queue: widths, codes and shared types.
// No dependencies.
package tvjq_pkg;

   localparam int QueueSlotsDefault = 16;
   localparam int FactorWidth       = 12;
   localparam int TimeWidth         = 32;
   localparam int MinutesWidth      = 11;
   localparam int LineWidth         = 4;
   localparam int CsrIndexWidth     = 1;
   localparam logic [TimeWidth-1:0] SecondsPerDay = 32'd86400;
   localparam logic [5:0] SecondsPerMinute = 6'd60;
   localparam logic [FactorWidth-1:0] MaxFactorReset      = 12'd512;
   localparam logic [FactorWidth-1:0] TomorrowFactorReset = 12'd256;

   typedef enum logic [1:0] {
      JOB_NEW     = 2'd0,
      JOB_DELAYED = 2'd1,
      JOB_RUN     = 2'd2,
      JOB_OFF     = 2'd3
   } job_state_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_OPEN  = 2'd1,
      ACT_CLOSE = 2'd2
   } line_action_type;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MAX_FACTOR      = 1'b0,
      CSR_TOMORROW_FACTOR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [TimeWidth-1:0] start;
      logic [TimeWidth-1:0] stop;
      logic [LineWidth-1:0] line;
      job_state_type        state;
   } job_type;

   typedef struct packed {
      logic                   opcode;
      logic [TimeWidth-1:0]   now_seconds;
      logic [2:0]             weekday;
      logic [6:0]             run_days;
      logic [MinutesWidth-1:0] duration_minutes;
      logic [LineWidth-1:0]   output_line;
      logic [FactorWidth-1:0] drift_factor;
      logic                   line_busy;
   } req_type;

   typedef struct packed {
      logic [1:0]           line_action;
      logic [LineWidth-1:0] action_line;
      logic [1:0]           jobs_added;
      logic [3:0]           queue_count;
   } rsp_type;

endpackage

FILE: src/tvjq_req_if.sv
// Valid/ready channel carrying one request word.
// Depends on tvjq_pkg.
interface tvjq_req_if;
   import tvjq_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/tvjq_rsp_if.sv
// Valid/ready channel carrying one response word.
// Depends on tvjq_pkg.
interface tvjq_rsp_if;
   import tvjq_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/timed_valve_job_queue_unit.sv
// Timed valve job queue: request/response channels, config port, sequencer.
// Depends on tvjq_pkg, tvjq_req_if, tvjq_rsp_if, tvjq_job_ram, tvjq_duration.
//
// Use: each request word is a push (enqueue up to two timed jobs) or a tick
// (scan jobs in order, act on the first due one, then purge off jobs). Every
// request gives exactly one response word with the line action, jobs added
// and the queue count afterwards.
// Sequence: a push goes from acceptance to the response register by feeding the
// two-stage duration multiplier, a settle step, two memory writes and the
// response load. A tick scans the jobs, then purges off jobs, then loads the
// response; scan and purge step through the jobs one at a time, set by the
// single read and write port of the job memory. The next request can be
// taken in the cycle after the response loads.
// One request is worked at a time; ready is high only while idle. A finished
// response waits in the output register while the receiver stalls; the block
// may take the next request meanwhile but holds its response until the
// register is free.
// Reset empties the queue (count zero) and loads the factor registers with
// 512 and 256; the job memory needs no clearing since only written entries
// are read. Configuration writes are taken at any time, never stalled.
module timed_valve_job_queue_unit #(
   parameter int QUEUE_SLOTS = tvjq_pkg::QueueSlotsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tvjq_req_if.sink                              req,
   tvjq_rsp_if.source                            rsp,
   input  logic                                  csr_write_enable,
   input  logic [tvjq_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [tvjq_pkg::FactorWidth-1:0]      csr_write_data
);
   import tvjq_pkg::*;

   localparam int AddrWidth  = $clog2(QUEUE_SLOTS);
   localparam int CountWidth = $clog2(QUEUE_SLOTS + 1);
   localparam logic [CountWidth-1:0] AddLimit = CountWidth'(QUEUE_SLOTS - 1);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_P_MUL    = 10'b0000000010,
      ST_P_WR1    = 10'b0000000100,
      ST_P_WR2    = 10'b0000001000,
      ST_S_RD     = 10'b0000010000,
      ST_S_CHK    = 10'b0000100000,
      ST_C_RD     = 10'b0001000000,
      ST_C_WR     = 10'b0010000000,
      ST_DONE     = 10'b0100000000,
      ST_P_WAIT   = 10'b1000000000
   } fsm_type;

   fsm_type fsm_ff, fsm_in;
   logic [FactorWidth-1:0] max_factor_ff, tomorrow_factor_ff;
   logic [CountWidth-1:0]  count_ff, count_in;
   req_type                req_ff, req_in;
   logic [1:0]             mul_cnt_ff, mul_cnt_in;
   logic [CountWidth-1:0]  ptr_ff, ptr_in;     // read pointer
   logic [CountWidth-1:0]  wptr_ff, wptr_in;   // compaction write pointer
   logic [TimeWidth-1:0]   dur_tom_ff, dur_tom_in;
   logic [TimeWidth-1:0]   dur_now_ff, dur_now_in;
   logic                   add_tom_ff, add_tom_in;
   logic [1:0]             added_ff, added_in;
   line_action_type        act_ff, act_in;
   logic [LineWidth-1:0]   act_line_ff, act_line_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   wr_en;
   logic [AddrWidth-1:0]   wr_addr, rd_addr;
   job_type                wr_data, rd_data;
   logic [MinutesWidth-1:0] mul_minutes;
   logic [FactorWidth-1:0]  mul_factor;
   logic [TimeWidth-1:0]    mul_seconds;

   logic [FactorWidth-1:0] eff_factor;
   logic                   too_big;
   logic [2:0]             wday_clamped, next_day;
   logic                   req_fire, rsp_fire;
   logic [TimeWidth-1:0]   tom_start;

   tvjq_job_ram #(.Depth(QUEUE_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tvjq_duration u_dur (
      .clock   (clock),
      .minutes (mul_minutes),
      .factor  (mul_factor),
      .seconds (mul_seconds)
   );

   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign req.ready = (fsm_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   // push decode from the held request
   assign too_big      = req_ff.drift_factor > max_factor_ff;
   assign eff_factor   = too_big ? max_factor_ff : req_ff.drift_factor;
   assign wday_clamped = (req_ff.weekday > 3'd6) ? 3'd6 : req_ff.weekday;
   assign next_day     = (wday_clamped == 3'd6) ? 3'd0 : wday_clamped + 3'd1;
   assign tom_start    = req_ff.now_seconds + SecondsPerDay;
   assign mul_minutes  = req_ff.duration_minutes;
   assign mul_factor   = (mul_cnt_ff == 2'd0) ? tomorrow_factor_ff : eff_factor;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_factor_ff      <= MaxFactorReset;
         tomorrow_factor_ff <= TomorrowFactorReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_FACTOR:      max_factor_ff      <= csr_write_data;
            CSR_TOMORROW_FACTOR: tomorrow_factor_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      fsm_in       = fsm_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      mul_cnt_in   = mul_cnt_ff;
      ptr_in       = ptr_ff;
      wptr_in      = wptr_ff;
      dur_tom_in   = dur_tom_ff;
      dur_now_in   = dur_now_ff;
      add_tom_in   = add_tom_ff;
      added_in     = added_ff;
      act_in       = act_ff;
      act_line_in  = act_line_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff[AddrWidth-1:0];
      wr_data      = rd_data;
      rd_addr      = ptr_ff[AddrWidth-1:0];
      unique case (fsm_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in      = req.data;
               added_in    = 2'd0;
               act_in      = ACT_NONE;
               act_line_in = '0;
               ptr_in      = '0;
               wptr_in     = '0;
               mul_cnt_in  = 2'd0;
               fsm_in      = (req.data.opcode == OP_TICK) ? ST_S_RD : ST_P_MUL;
            end
         end
         ST_P_MUL: begin
            // feed tomorrow factor then effective factor, collect each after both multiplier stages
            mul_cnt_in = mul_cnt_ff + 2'd1;
            if (mul_cnt_ff == 2'd2) dur_tom_in = mul_seconds;
            if (mul_cnt_ff == 2'd3) begin
               dur_now_in = mul_seconds;
               add_tom_in = too_big && !req_ff.run_days[next_day];
               fsm_in     = ST_P_WAIT;
            end
         end
         ST_P_WAIT: begin
            fsm_in = ST_P_WR1;
         end
         ST_P_WR1: begin
            // next-day job
            if (add_tom_ff && count_ff < AddLimit) begin
               wr_en          = 1'b1;
               wr_addr        = count_ff[AddrWidth-1:0];
               wr_data.start  = tom_start;
               wr_data.stop   = tom_start + dur_tom_ff;
               wr_data.line   = req_ff.output_line;
               wr_data.state  = JOB_NEW;
               count_in       = count_ff + 1'b1;
               added_in       = added_ff + 2'd1;
            end
            fsm_in = ST_P_WR2;
         end
         ST_P_WR2: begin
            // job for now
            if (eff_factor != '0 && count_ff < AddLimit) begin
               wr_en          = 1'b1;
               wr_addr        = count_ff[AddrWidth-1:0];
               wr_data.start  = req_ff.now_seconds;
               wr_data.stop   = req_ff.now_seconds + dur_now_ff;
               wr_data.line   = req_ff.output_line;
               wr_data.state  = JOB_NEW;
               count_in       = count_ff + 1'b1;
               added_in       = added_ff + 2'd1;
            end
            fsm_in = ST_DONE;
         end
         ST_S_RD: begin
            if (ptr_ff >= count_ff) begin
               ptr_in = '0;
               fsm_in = ST_C_RD;
            end else begin
               fsm_in = ST_S_CHK;
            end
         end
         ST_S_CHK: begin
            // examine one job; write back any change
            fsm_in = ST_S_RD;
            ptr_in = ptr_ff + 1'b1;
            if (rd_data.start <= req_ff.now_seconds) begin
               case (rd_data.state) inside
                  JOB_NEW, JOB_DELAYED: begin
                     if (!req_ff.line_busy) begin
                        wr_en         = 1'b1;
                        wr_data.stop  = rd_data.stop + (req_ff.now_seconds - rd_data.start);
                        wr_data.start = req_ff.now_seconds;
                        wr_data.state = JOB_RUN;
                        act_in        = ACT_OPEN;
                        act_line_in   = rd_data.line;
                        ptr_in        = '0;
                        fsm_in        = ST_C_RD;
                     end else if (rd_data.state == JOB_NEW) begin
                        wr_en         = 1'b1;
                        wr_data.state = JOB_DELAYED;
                     end
                  end
                  JOB_RUN: begin
                     if (rd_data.stop <= req_ff.now_seconds) begin
                        wr_en         = 1'b1;
                        wr_data.state = JOB_OFF;
                        act_in        = ACT_CLOSE;
                        act_line_in   = rd_data.line;
                        ptr_in        = '0;
                        fsm_in        = ST_C_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_C_RD: begin
            if (ptr_ff >= count_ff) begin
               count_in = wptr_ff;
               fsm_in   = ST_DONE;
            end else begin
               fsm_in = ST_C_WR;
            end
         end
         ST_C_WR: begin
            // keep live jobs, closing up the gaps
            wr_addr = wptr_ff[AddrWidth-1:0];
            if (rd_data.state != JOB_OFF) begin
               wr_en   = 1'b1;
               wptr_in = wptr_ff + 1'b1;
            end
            ptr_in = ptr_ff + 1'b1;
            fsm_in = ST_C_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_fire) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.line_action = act_ff;
               rsp_data_in.action_line = act_line_ff;
               rsp_data_in.jobs_added  = added_ff;
               rsp_data_in.queue_count = 4'(count_ff);
               fsm_in                  = ST_IDLE;
            end
         end
         default: fsm_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      mul_cnt_ff  <= mul_cnt_in;
      ptr_ff      <= ptr_in;
      wptr_ff     <= wptr_in;
      dur_tom_ff  <= dur_tom_in;
      dur_now_ff  <= dur_now_in;
      add_tom_ff  <= add_tom_in;
      added_ff    <= added_in;
      act_ff      <= act_in;
      act_line_ff <= act_line_in;
      rsp_data_ff <= rsp_data_in;
   end

   // queue never passes its add limit
   assert property (@(posedge clock) disable iff (reset) count_ff <= AddLimit)
      else $error("queue count beyond limit");

   // each push write step adds at most one job to the count
   assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_P_WR1 || fsm_ff == ST_P_WR2) |=> count_ff <= $past(count_ff) + 1'b1)
      else $error("push step added more than one job");

   // a stalled response stays valid and unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled response lost");

   // compaction write pointer never overtakes the read pointer
   assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_C_RD || fsm_ff == ST_C_WR) |-> wptr_ff <= ptr_ff)
      else $error("compaction pointers crossed");
endmodule

FILE: src/tvjq_job_ram.sv
// Job store: one synchronous memory, one write and one read port, registered read.
// Depends on tvjq_pkg.
module tvjq_job_ram #(
   parameter int Depth = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(Depth)-1:0]      wr_addr,
   input  tvjq_pkg::job_type             wr_data,
   input  logic [$clog2(Depth)-1:0]      rd_addr,
   output tvjq_pkg::job_type             rd_data
);
   import tvjq_pkg::*;

   job_type mem [Depth];
   job_type rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/tvjq_duration.sv
// Duration scaler: minutes * 60 * factor / 256 over two registered stages.
// Depends on tvjq_pkg.
module tvjq_duration (
   input  logic                                  clock,
   input  logic [tvjq_pkg::MinutesWidth-1:0]     minutes,
   input  logic [tvjq_pkg::FactorWidth-1:0]      factor,
   output logic [tvjq_pkg::TimeWidth-1:0]        seconds
);
   import tvjq_pkg::*;

   logic [MinutesWidth+5:0]              secs_ff;
   logic [FactorWidth-1:0]               factor_ff;
   logic [MinutesWidth+FactorWidth+5:0]  prod_ff;

   // stage one: minutes to seconds; stage two: scale
   always_ff @(posedge clock) begin
      secs_ff   <= MinutesWidth'(minutes) * (MinutesWidth+6)'(SecondsPerMinute);
      factor_ff <= factor;
      prod_ff   <= (MinutesWidth+FactorWidth+6)'(secs_ff) *
                   (MinutesWidth+FactorWidth+6)'(factor_ff);
   end

   assign seconds = TimeWidth'(prod_ff >> 8);
endmodule

FILE: sim/timed_valve_job_queue_unit_test.sv
// Self-checking bench for the timed valve job queue: drives push and tick words,
// predicts every response and compares it field by field.
// Depends on tvjq_pkg, tvjq_req_if, tvjq_rsp_if and timed_valve_job_queue_unit.
module timed_valve_job_queue_unit_test;
   import tvjq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Slots = 16;
   localparam int IdleLimit = 20000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [FactorWidth-1:0] csr_write_data;

   tvjq_req_if req ();
   tvjq_rsp_if rsp ();

   timed_valve_job_queue_unit #(.QUEUE_SLOTS(Slots)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor state
   logic [FactorWidth-1:0] clamp_factor;
   logic [FactorWidth-1:0] next_day_factor;
   job_type jobs [Slots];
   int unsigned held_jobs;

   req_type pending_words [$];
   rsp_type awaited_rsp [$];
   int errors;
   int idle_cycles;
   int word_gap;
   int rsp_gap;
   int pushes_sent;
   int ticks_sent;
   int opens_seen;
   int closes_seen;
   bit timed_out;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [TimeWidth-1:0] scaled_secs(logic [MinutesWidth-1:0] mins,
                                                        logic [FactorWidth-1:0] fac);
      logic [63:0] prod;
      prod = 64'(mins) * 64'd60 * 64'(fac);
      return prod[39:8];
   endfunction

   function automatic bit enqueue_job(logic [TimeWidth-1:0] s, logic [TimeWidth-1:0] e,
                                      logic [LineWidth-1:0] ln);
      if (held_jobs >= Slots - 1) return 1'b0;
      jobs[held_jobs].start = s;
      jobs[held_jobs].stop = e;
      jobs[held_jobs].line = ln;
      jobs[held_jobs].state = JOB_NEW;
      held_jobs++;
      return 1'b1;
   endfunction

   function automatic void open_job(int k, logic [TimeWidth-1:0] now);
      jobs[k].stop = jobs[k].stop + (now - jobs[k].start);
      jobs[k].start = now;
      jobs[k].state = JOB_RUN;
   endfunction

   // work out the response of one word and advance the queue model
   function automatic rsp_type predict_queue(req_type w);
      rsp_type r;
      logic [FactorWidth-1:0] f;
      logic [2:0] wd;
      logic [2:0] nd;
      int unsigned wr;
      bit done;
      r = '0;
      if (w.opcode == OP_PUSH) begin
         f = w.drift_factor;
         if (f > clamp_factor) begin
            f = clamp_factor;
            wd = (w.weekday > 3'd6) ? 3'd6 : w.weekday;
            nd = (wd == 3'd6) ? 3'd0 : wd + 3'd1;
            if (!w.run_days[nd]) begin
               if (enqueue_job(w.now_seconds + SecondsPerDay,
                               w.now_seconds + SecondsPerDay +
                               scaled_secs(w.duration_minutes, next_day_factor),
                               w.output_line))
                  r.jobs_added++;
            end
         end
         if (f > 0) begin
            if (enqueue_job(w.now_seconds,
                            w.now_seconds + scaled_secs(w.duration_minutes, f),
                            w.output_line))
               r.jobs_added++;
         end
      end else begin
         done = 1'b0;
         for (int k = 0; k < held_jobs && !done; k++) begin
            if (jobs[k].start > w.now_seconds) continue;
            case (jobs[k].state)
               JOB_NEW: begin
                  if (w.line_busy) jobs[k].state = JOB_DELAYED;
                  else begin
                     open_job(k, w.now_seconds);
                     r.line_action = ACT_OPEN;
                     r.action_line = jobs[k].line;
                     done = 1'b1;
                  end
               end
               JOB_DELAYED: begin
                  if (!w.line_busy) begin
                     open_job(k, w.now_seconds);
                     r.line_action = ACT_OPEN;
                     r.action_line = jobs[k].line;
                     done = 1'b1;
                  end
               end
               JOB_RUN: begin
                  if (jobs[k].stop <= w.now_seconds) begin
                     jobs[k].state = JOB_OFF;
                     r.line_action = ACT_CLOSE;
                     r.action_line = jobs[k].line;
                     done = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         // drop off jobs and close up the queue
         wr = 0;
         for (int k = 0; k < held_jobs; k++) begin
            if (jobs[k].state != JOB_OFF) begin
               jobs[wr] = jobs[k];
               wr++;
            end
         end
         held_jobs = wr;
      end
      r.queue_count = held_jobs[3:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // drive request words at the falling edge
   always @(negedge clock) begin
      int gap;
      if (reset) begin
         req.valid <= 1'b0;
         word_gap <= 0;
      end else if (!(req.valid && !req.ready)) begin
         gap = word_gap;
         if (req.valid && req.ready) gap = pick_gap();
         if (gap > 0) begin
            word_gap <= gap - 1;
            req.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            word_gap <= 0;
            req.data <= pending_words.pop_front();
            req.valid <= 1'b1;
         end else begin
            word_gap <= 0;
            req.valid <= 1'b0;
         end
      end
   end

   // toggle the response stall at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp.ready <= 1'b0;
      end else if (rsp.ready && rsp.valid) begin
         rsp_gap <= pick_gap();
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // predict on each accepted word, check each accepted response
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req.valid && req.ready) begin
            awaited_rsp.push_back(predict_queue(req.data));
            if (req.data.opcode == OP_PUSH) pushes_sent++;
            else ticks_sent++;
            moved = 1'b1;
         end
         if (rsp.valid && rsp.ready) begin
            moved = 1'b1;
            got = rsp.data;
            if (awaited_rsp.size() == 0) begin
               $error("response word with nothing awaited");
               errors++;
            end else begin
               want = awaited_rsp.pop_front();
               if (got.line_action == ACT_OPEN) opens_seen++;
               if (got.line_action == ACT_CLOSE) closes_seen++;
               if (got.line_action !== want.line_action) begin
                  $error("line_action expected %0d got %0d", want.line_action,
                         got.line_action);
                  errors++;
               end
               if (got.action_line !== want.action_line) begin
                  $error("action_line expected %0d got %0d", want.action_line,
                         got.action_line);
                  errors++;
               end
               if (got.jobs_added !== want.jobs_added) begin
                  $error("jobs_added expected %0d got %0d", want.jobs_added,
                         got.jobs_added);
                  errors++;
               end
               if (got.queue_count !== want.queue_count) begin
                  $error("queue_count expected %0d got %0d", want.queue_count,
                         got.queue_count);
                  errors++;
               end
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset && idle_cycles >= IdleLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired with %0d words awaited", awaited_rsp.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type push_word(logic [31:0] now, logic [2:0] wd, logic [6:0] days,
                                         logic [10:0] mins, logic [3:0] ln,
                                         logic [11:0] fac);
      req_type w;
      w = '0;
      w.opcode = OP_PUSH;
      w.now_seconds = now;
      w.weekday = wd;
      w.run_days = days;
      w.duration_minutes = mins;
      w.output_line = ln;
      w.drift_factor = fac;
      w.line_busy = 1'($urandom_range(0, 1));
      return w;
   endfunction

   function automatic req_type tick_word(logic [31:0] now, bit busy);
      req_type w;
      w = '0;
      w.opcode = OP_TICK;
      w.now_seconds = now;
      w.line_busy = busy;
      w.weekday = 3'($urandom());
      w.run_days = 7'($urandom());
      w.duration_minutes = 11'($urandom());
      w.output_line = 4'($urandom());
      w.drift_factor = 12'($urandom());
      return w;
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || awaited_rsp.size() > 0 || req.valid)
         @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [FactorWidth-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MAX_FACTOR) clamp_factor = val;
      else next_day_factor = val;
   endtask

   // one random phase: pushes and ticks mixed at random around a moving clock
   task automatic random_phase(int words);
      logic [31:0] now;
      logic [31:0] base;
      logic [10:0] mins;
      int roll;
      now = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                        : $urandom();
      for (int i = 0; i < words; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            mins = ($urandom_range(0, 19) == 0) ? 11'($urandom_range(0, 1440))
                                                 : 11'($urandom_range(0, 8));
            if ($urandom_range(0, 29) == 0) mins = 11'($urandom());
            base = ($urandom_range(0, 3) == 0) ? now + $urandom_range(0, 600) : now;
            pending_words.push_back(push_word(base, 3'($urandom()), 7'($urandom()), mins,
                                              4'($urandom()), 12'($urandom())));
         end else begin
            now = now + (($urandom_range(0, 9) == 0) ? $urandom_range(60, 90000)
                                                      : $urandom_range(0, 200));
            if ($urandom_range(0, 39) == 0) now = $urandom();
            pending_words.push_back(tick_word(now, $urandom_range(0, 3) == 0));
         end
      end
   endtask

   initial begin
      logic [31:0] t;
      errors = 0;
      idle_cycles = 0;
      pushes_sent = 0;
      ticks_sent = 0;
      opens_seen = 0;
      closes_seen = 0;
      timed_out = 1'b0;
      held_jobs = 0;
      clamp_factor = MaxFactorReset;
      next_day_factor = TomorrowFactorReset;
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, both weekday wraps, zero factor, full queue
      t = 32'hFFFF_FFF0;
      pending_words.push_back(push_word(t, 3'd6, 7'h7E, 11'd1440, 4'd15, 12'hFFF));
      pending_words.push_back(push_word(t, 3'd7, 7'h01, 11'd0, 4'd0, 12'hFFF));
      pending_words.push_back(push_word(t, 3'd0, 7'h7F, 11'h7FF, 4'd5, 12'd0));
      pending_words.push_back(push_word(t, 3'd2, 7'h00, 11'd1, 4'd9, 12'd513));
      pending_words.push_back(tick_word(t, 1'b1));
      pending_words.push_back(tick_word(t, 1'b0));
      pending_words.push_back(tick_word(t + 32'd10, 1'b0));
      pending_words.push_back(tick_word(32'hFFFF_FFFF, 1'b0));
      for (int i = 0; i < 9; i++)
         pending_words.push_back(push_word(32'd100, 3'(i), 7'h00, 11'd2, 4'(i), 12'd600));
      pending_words.push_back(tick_word(32'd0, 1'b0));
      for (int i = 0; i < 6; i++)
         pending_words.push_back(tick_word(32'd200 + 32'(i) * 32'd200, i[0]));
      wait_drained();

      // random phases across several factor settings, extremes included
      write_csr(CSR_MAX_FACTOR, 12'hFFF);
      write_csr(CSR_TOMORROW_FACTOR, 12'd0);
      random_phase(200);
      wait_drained();
      write_csr(CSR_MAX_FACTOR, 12'd0);
      write_csr(CSR_TOMORROW_FACTOR, 12'hFFF);
      random_phase(150);
      wait_drained();
      write_csr(CSR_MAX_FACTOR, 12'd128);
      write_csr(CSR_TOMORROW_FACTOR, 12'd300);
      random_phase(250);
      wait_drained();
      write_csr(CSR_MAX_FACTOR, 12'($urandom()));
      write_csr(CSR_TOMORROW_FACTOR, 12'($urandom()));
      random_phase(250);
      wait_drained();

      $display("covered %0d pushes and %0d ticks, %0d opens and %0d closes observed",
               pushes_sent, ticks_sent, opens_seen, closes_seen);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
